@@ rtl/rbms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Behavior mode selector package
// Shared mode, drive, sound and command codes, tuning constants and the
// structs passed between the selector modules.
// ----------------------------------------------------------------------------
package rbms_pkg;

  typedef enum logic [2:0] {
    MODE_PAUSED  = 3'd0,
    MODE_FORWARD = 3'd1,
    MODE_REACT   = 3'd2,
    MODE_TURN    = 3'd3,
    MODE_EXPLORE = 3'd4,
    MODE_RLEFT   = 3'd5,
    MODE_RRIGHT  = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    DRIVE_FWD  = 3'd0,
    DRIVE_CCW  = 3'd1,
    DRIVE_CW   = 3'd2,
    DRIVE_BACK = 3'd3,
    DRIVE_STOP = 3'd4
  } drive_t;

  typedef enum logic [1:0] {
    SOUND_NONE    = 2'd0,
    SOUND_HIT     = 2'd1,
    SOUND_EXPLORE = 2'd2,
    SOUND_NOHIT   = 2'd3
  } sound_t;

  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_PAUSE    = 3'd1;
  localparam logic [2:0] CMD_START    = 3'd2;
  localparam logic [2:0] CMD_PRED_ON  = 3'd3;
  localparam logic [2:0] CMD_PRED_OFF = 3'd4;

  localparam int unsigned BTN_PAUSE_BIT = 2;
  localparam int unsigned BTN_START_BIT = 0;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAND_TURN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;

  localparam logic [7:0] REACT_STEPS        = 8'd10;
  localparam logic [7:0] EXPLORE_STEPS      = 8'd40;
  localparam logic [7:0] EXPLORE_STOP_STEPS = 8'd7;
  localparam logic [7:0] STEP_MAX           = 8'd255;

  // 0.505 in signed Q4.12.
  localparam logic signed [15:0] THRESHOLD_RESET = 16'sd2068;

  // Divisibility flags of the first random word.
  typedef struct packed {
    logic div5;
    logic div10;
    logic div20;
    logic div50;
  } odds_t;

  // Registered behavior state.
  typedef struct packed {
    mode_t      mode;
    logic [7:0] steps;
    logic       pred_en;
  } state_t;

  // One tick's result.
  typedef struct packed {
    drive_t     drive;
    sound_t     sound;
    mode_t      mode;
    logic [7:0] steps;
  } result_t;

endpackage

@@ rtl/rbms_odds.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random word divisibility
// Tells whether a 31-bit random word is divisible by 5, 10, 20 and 50.
// ----------------------------------------------------------------------------
module rbms_odds (
  input  logic [30:0]   rand_word,
  output rbms_pkg::odds_t odds
);

  // Remainder mod 25: 1024 is -1 mod 25, so 10-bit digits fold with
  // alternating sign. An offset of 1025 (a multiple of 25) keeps sums positive.
  logic [11:0] fold1;
  logic [10:0] fold2;
  logic [21:0] prod;
  logic [6:0]  quot;
  logic [10:0] rem_full;
  logic [4:0]  rem25;

  assign fold1 = {2'b00, rand_word[9:0]} + {1'b0, rand_word[30:20]} + 12'd1025
               - {2'b00, rand_word[19:10]};
  assign fold2 = {1'b0, fold1[9:0]} + 11'd25 - {9'd0, fold1[11:10]};

  // fold2 stays below 1049, where 1311 / 2^15 gives an exact quotient by 25.
  assign prod     = {11'd0, fold2} * 22'd1311;
  assign quot     = prod[21:15];
  assign rem_full = fold2 - 11'({quot, 4'b0000} + {quot, 3'b000} + {4'd0, quot});
  assign rem25    = rem_full[4:0];

  logic div5;
  logic div25;

  assign div5  = (rem25 == 5'd0) || (rem25 == 5'd5) || (rem25 == 5'd10) ||
                 (rem25 == 5'd15) || (rem25 == 5'd20);
  assign div25 = (rem25 == 5'd0);

  assign odds.div5  = div5;
  assign odds.div10 = div5 && !rand_word[0];
  assign odds.div20 = div5 && (rand_word[1:0] == 2'b00);
  assign odds.div50 = div25 && !rand_word[0];

endmodule

@@ rtl/rbms_decide.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Behavior decision logic
// Applies remote and button control, then the mode transition rules, and
// forms the next state and the tick's result.
// ----------------------------------------------------------------------------
module rbms_decide (
  input  rbms_pkg::state_t     cur,
  input  logic                 rand_turn_en,
  input  logic signed [15:0]   threshold,
  input  logic                 bump,
  input  logic [2:0]           command,
  input  logic [7:0]           buttons,
  input  logic signed [15:0]   prediction,
  input  rbms_pkg::odds_t      odds,
  input  logic                 rand_odd,
  output rbms_pkg::state_t     nxt,
  output rbms_pkg::result_t    res
);

  logic            pause;
  logic            start;
  rbms_pkg::mode_t mode_in;
  logic            pen;
  rbms_pkg::mode_t nm;
  rbms_pkg::sound_t snd;
  logic [7:0]      steps_new;

  assign pause = (command == rbms_pkg::CMD_PAUSE) || buttons[rbms_pkg::BTN_PAUSE_BIT];
  assign start = (command == rbms_pkg::CMD_START) || buttons[rbms_pkg::BTN_START_BIT];

  always_comb begin
    mode_in = cur.mode;
    pen     = cur.pred_en;
    if (pause) begin
      mode_in = rbms_pkg::MODE_PAUSED;
    end else if (start) begin
      mode_in = rbms_pkg::MODE_FORWARD;
    end else if (command == rbms_pkg::CMD_PRED_ON) begin
      pen = 1'b1;
    end else if (command == rbms_pkg::CMD_PRED_OFF) begin
      pen = 1'b0;
    end
  end

  // Next mode and sound: first rule that holds wins.
  always_comb begin
    nm  = mode_in;
    snd = rbms_pkg::SOUND_NONE;
    if (mode_in == rbms_pkg::MODE_PAUSED) begin
      nm = rbms_pkg::MODE_PAUSED;
    end else if (mode_in != rbms_pkg::MODE_REACT && bump) begin
      nm = rbms_pkg::MODE_REACT;
      if (mode_in != rbms_pkg::MODE_EXPLORE) begin
        snd = rbms_pkg::SOUND_HIT;
      end
    end else if (mode_in == rbms_pkg::MODE_REACT && !bump &&
                 cur.steps > rbms_pkg::REACT_STEPS) begin
      nm = rbms_pkg::MODE_TURN;
    end else if (mode_in == rbms_pkg::MODE_FORWARD && pen && prediction > threshold) begin
      if (odds.div20) begin
        nm  = rbms_pkg::MODE_EXPLORE;
        snd = rbms_pkg::SOUND_EXPLORE;
      end else begin
        nm = rbms_pkg::MODE_TURN;
      end
    end else if (mode_in == rbms_pkg::MODE_FORWARD && rand_turn_en && odds.div50) begin
      nm = rand_odd ? rbms_pkg::MODE_RLEFT : rbms_pkg::MODE_RRIGHT;
    end else if ((mode_in == rbms_pkg::MODE_RLEFT || mode_in == rbms_pkg::MODE_RRIGHT) &&
                 odds.div10) begin
      nm = rbms_pkg::MODE_FORWARD;
    end else if (mode_in == rbms_pkg::MODE_EXPLORE) begin
      if (cur.steps > rbms_pkg::EXPLORE_STEPS) begin
        nm  = rbms_pkg::MODE_FORWARD;
        snd = rbms_pkg::SOUND_NOHIT;
      end
    end else if (!bump && mode_in == rbms_pkg::MODE_TURN &&
                 cur.steps >= rbms_pkg::REACT_STEPS && odds.div5) begin
      nm = rbms_pkg::MODE_FORWARD;
    end
  end

  always_comb begin
    if (mode_in == rbms_pkg::MODE_PAUSED) begin
      steps_new = cur.steps;
    end else if (nm != mode_in) begin
      steps_new = 8'd0;
    end else if (cur.steps != rbms_pkg::STEP_MAX) begin
      steps_new = cur.steps + 8'd1;
    end else begin
      steps_new = cur.steps;
    end
  end

  assign nxt.mode    = nm;
  assign nxt.steps   = steps_new;
  assign nxt.pred_en = pen;

  // Outputs of the tick.
  always_comb begin
    res.mode  = nm;
    res.steps = steps_new;
    res.sound = snd;
    case (nm)
      rbms_pkg::MODE_PAUSED:  res.drive = rbms_pkg::DRIVE_STOP;
      rbms_pkg::MODE_FORWARD: res.drive = rbms_pkg::DRIVE_FWD;
      rbms_pkg::MODE_EXPLORE: res.drive = (steps_new < rbms_pkg::EXPLORE_STOP_STEPS) ?
                                          rbms_pkg::DRIVE_STOP : rbms_pkg::DRIVE_FWD;
      rbms_pkg::MODE_REACT:   res.drive = rbms_pkg::DRIVE_STOP;
      rbms_pkg::MODE_RLEFT:   res.drive = rbms_pkg::DRIVE_CCW;
      rbms_pkg::MODE_RRIGHT:  res.drive = rbms_pkg::DRIVE_CW;
      default:                res.drive = rbms_pkg::DRIVE_CCW;
    endcase
  end

endmodule

@@ rtl/robot_behavior_mode_selector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robot behavior mode selector
// Flow: a tick waits in the input register until the decision pass fires;
//   its result is then held and offered in the output register.
// Throughput: one tick per cycle with out_ready high; the single decision
//   pass from the input register to the output and state registers sets it.
// Reset: mode paused, step count 0, prediction on, random turns off,
//   threshold 2068 (0.505 in Q4.12), both pipeline registers empty.
// ----------------------------------------------------------------------------
module robot_behavior_mode_selector (
  input  logic                            clk,
  input  logic                            rst,
  // Tick input channel.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            bump,
  input  logic [2:0]                      command,
  input  logic [7:0]                      buttons,
  input  logic signed [15:0]              prediction,
  input  logic [30:0]                     rand_first,
  input  logic [30:0]                     rand_second,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      drive,
  output logic [1:0]                      sound,
  output logic [2:0]                      behavior_mode,
  output logic [7:0]                      steps_in_mode,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rbms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data
);

  // Configuration registers. The user must send writes only while the block
  // is idle; the block does not enforce it. The port is always ready.
  logic               rand_turn_en;
  logic signed [15:0] threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rand_turn_en <= 1'b0;
      threshold    <= rbms_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rbms_pkg::CFG_RAND_TURN: rand_turn_en <= cfg_data[0];
        rbms_pkg::CFG_THRESHOLD: threshold    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register. It holds one tick until the decision pass can deliver
  // its result into the output register.
  logic               in_full;
  logic               in_bump;
  logic [2:0]         in_command;
  logic [7:0]         in_buttons;
  logic signed [15:0] in_prediction;
  logic [30:0]        in_rand_first;
  logic               in_rand_odd;

  // The decision pass fires when a tick is held and the output register is
  // free or being emptied this cycle. State and result update together, so
  // ticks are decided strictly in order.
  logic advance;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_bump       <= bump;
      in_command    <= command;
      in_buttons    <= buttons;
      in_prediction <= prediction;
      in_rand_first <= rand_first;
      in_rand_odd   <= rand_second[0];
    end
  end

  // Behavior state.
  rbms_pkg::state_t state;
  rbms_pkg::state_t state_next;
  rbms_pkg::result_t result_next;
  rbms_pkg::odds_t  odds;

  rbms_odds u_odds (
    .rand_word (in_rand_first),
    .odds      (odds)
  );

  rbms_decide u_decide (
    .cur          (state),
    .rand_turn_en (rand_turn_en),
    .threshold    (threshold),
    .bump         (in_bump),
    .command      (in_command),
    .buttons      (in_buttons),
    .prediction   (in_prediction),
    .odds         (odds),
    .rand_odd     (in_rand_odd),
    .nxt          (state_next),
    .res          (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode    <= rbms_pkg::MODE_PAUSED;
      state.steps   <= 8'd0;
      state.pred_en <= 1'b1;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register. A finished result waits here while the next tick is
  // already taken into the input register.
  rbms_pkg::result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign drive         = 3'(result.drive);
  assign sound         = 2'(result.sound);
  assign behavior_mode = 3'(result.mode);
  assign steps_in_mode = result.steps;

endmodule
